@@ rtl/crt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the contact reference count table.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int BODY_W  = 32;
  localparam int COUNT_W = 16;
  localparam int EV_W    = 2;

  localparam int DEF_CONTACT_SLOTS = 16;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_BEGAN = 2'd1;
  localparam logic [EV_W-1:0] EV_ENDED = 2'd2;
  localparam logic [EV_W-1:0] EV_FULL  = 2'd3;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture a transaction and its slot match vector
    logic exec;   // update the table and issue the result
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/crt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: accepts a transaction, then runs the table update.
// ----------------------------------------------------------------------------
module crt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  output crt_pkg::ctl_t    ctl
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
            busy_r  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy     = busy_r;
  assign ctl.load = start && !busy_r;
  assign ctl.exec = (state_r == ST_EXEC);

endmodule
`default_nettype wire

@@ rtl/crt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_datapath
// Slot table, parallel id compare, count update and result registers.
// ----------------------------------------------------------------------------
module crt_datapath #(
  parameter int CONTACT_SLOTS = crt_pkg::DEF_CONTACT_SLOTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire crt_pkg::ctl_t                ctl,
  input  wire logic                         cfg_we,
  input  wire logic [crt_pkg::BODY_W-1:0]   cfg_wdata,
  input  wire logic                         in_command,
  input  wire logic [crt_pkg::BODY_W-1:0]   in_body_a,
  input  wire logic [crt_pkg::BODY_W-1:0]   in_body_b,
  output logic                              out_valid,
  output logic [crt_pkg::EV_W-1:0]          out_event_res,
  output logic [crt_pkg::BODY_W-1:0]        out_peer_body,
  output logic [crt_pkg::COUNT_W-1:0]       out_pair_count
);

  localparam int SLOT_IW = (CONTACT_SLOTS > 1) ? $clog2(CONTACT_SLOTS) : 1;

  logic [crt_pkg::BODY_W-1:0]  own_body_r;

  logic                        valid_r [CONTACT_SLOTS];
  logic [crt_pkg::BODY_W-1:0]  body_r  [CONTACT_SLOTS];
  logic [crt_pkg::COUNT_W-1:0] count_r [CONTACT_SLOTS];

  // captured transaction
  logic                        cmd_r;
  logic                        own_hit_r;
  logic [crt_pkg::BODY_W-1:0]  other_r;
  logic [CONTACT_SLOTS-1:0]    match_r;

  logic                        hit_a;
  logic                        hit_b;
  logic [CONTACT_SLOTS-1:0]    match_a;
  logic [CONTACT_SLOTS-1:0]    match_b;

  logic                        found;
  logic [SLOT_IW-1:0]          found_idx;
  logic                        free_found;
  logic [SLOT_IW-1:0]          free_idx;
  logic [crt_pkg::COUNT_W-1:0] cur_cnt;

  logic                        wr_en;
  logic [SLOT_IW-1:0]          wr_idx;
  logic                        wr_valid;
  logic                        wr_body_en;
  logic [crt_pkg::COUNT_W-1:0] wr_count;
  logic [crt_pkg::EV_W-1:0]    ev_nxt;
  logic [crt_pkg::COUNT_W-1:0] cnt_nxt;

  logic                        out_valid_r;
  logic [crt_pkg::EV_W-1:0]    out_ev_r;
  logic [crt_pkg::BODY_W-1:0]  out_other_r;
  logic [crt_pkg::COUNT_W-1:0] out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_body_r <= '0;
    end else if (cfg_we) begin
      own_body_r <= cfg_wdata;
    end
  end

  // compare both ids against every slot, then pick by which side is own
  assign hit_a = (in_body_a == own_body_r);
  assign hit_b = (in_body_b == own_body_r);

  always_comb begin
    for (int i = 0; i < CONTACT_SLOTS; i++) begin
      match_a[i] = valid_r[i] && (body_r[i] == in_body_a);
      match_b[i] = valid_r[i] && (body_r[i] == in_body_b);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= in_command;
      own_hit_r <= hit_a || hit_b;
      if (hit_a) begin
        other_r <= in_body_b;
        match_r <= match_b;
      end else if (hit_b) begin
        other_r <= in_body_a;
        match_r <= match_a;
      end else begin
        other_r <= '0;
        match_r <= '0;
      end
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    found      = 1'b0;
    found_idx  = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CONTACT_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        found     = 1'b1;
        found_idx = SLOT_IW'(i);
      end
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IW'(i);
      end
    end
  end

  assign cur_cnt = count_r[found_idx];

  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = found_idx;
    wr_valid   = 1'b1;
    wr_body_en = 1'b0;
    wr_count   = cur_cnt;
    ev_nxt     = crt_pkg::EV_NONE;
    cnt_nxt    = '0;
    if (own_hit_r) begin
      if (cmd_r == crt_pkg::CMD_BEGIN) begin
        if (found) begin
          wr_en    = 1'b1;
          wr_count = (cur_cnt == crt_pkg::COUNT_MAX) ? cur_cnt
                                                      : cur_cnt + crt_pkg::COUNT_W'(1);
          cnt_nxt  = wr_count;
        end else if (free_found) begin
          wr_en      = 1'b1;
          wr_idx     = free_idx;
          wr_body_en = 1'b1;
          wr_count   = crt_pkg::COUNT_W'(1);
          ev_nxt     = crt_pkg::EV_BEGAN;
          cnt_nxt    = crt_pkg::COUNT_W'(1);
        end else begin
          ev_nxt = crt_pkg::EV_FULL;
        end
      end else if (found) begin
        wr_en = 1'b1;
        if (cur_cnt > crt_pkg::COUNT_W'(1)) begin
          wr_count = cur_cnt - crt_pkg::COUNT_W'(1);
          cnt_nxt  = wr_count;
        end else begin
          wr_valid = 1'b0;
          ev_nxt   = crt_pkg::EV_ENDED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONTACT_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (ctl.exec && wr_en) begin
      for (int i = 0; i < CONTACT_SLOTS; i++) begin
        if (wr_idx == SLOT_IW'(i)) begin
          valid_r[i] <= wr_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      for (int i = 0; i < CONTACT_SLOTS; i++) begin
        if (wr_idx == SLOT_IW'(i)) begin
          count_r[i] <= wr_count;
          if (wr_body_en) begin
            body_r[i] <= other_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_ev_r    <= ev_nxt;
      out_other_r <= other_r;
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_ev_r;
  assign out_peer_body  = out_other_r;
  assign out_pair_count = out_cnt_r;

  // at most one valid slot per body id
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> $onehot0(match_r))
    else $error("multiple slots match one body");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> out_valid_r)
    else $error("update cycle without result strobe");

  a_foreign_none: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && !own_hit_r) |=> (out_ev_r == crt_pkg::EV_NONE && out_cnt_r == '0
                                  && out_other_r == '0))
    else $error("foreign pair produced an event");

  a_began_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r == crt_pkg::EV_BEGAN) |-> (out_cnt_r == crt_pkg::COUNT_W'(1)))
    else $error("new contact without count one");

  a_ended_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ev_r == crt_pkg::EV_ENDED || out_ev_r == crt_pkg::EV_FULL))
      |-> (out_cnt_r == '0))
    else $error("ended or dropped contact with nonzero count");

endmodule
`default_nettype wire

@@ rtl/contact_refcount_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contact_refcount_table
// Reference-counted table of bodies in contact with one tracked body.
//
// Usage:
//   Input: drive in_command/in_body_a/in_body_b and raise start; the
//   transaction is taken on a clock edge where start is high and busy is
//   low. busy then stays high for one cycle while the table is updated.
//   Output: one result per transaction, shown for exactly one cycle with
//   out_valid high, on the cycle after the update. The receiver cannot
//   stall; results must be taken as shown.
//   Sequence: each transaction has a capture cycle (parallel id compare
//   against all slots) and then an update cycle (slot select and count
//   add/subtract); no new one is taken until its update is done. A
//   new transaction may be accepted while the previous result is on the output.
//   Config: cfg_we/cfg_wdata write the tracked body id; write only while
//   no transaction is in flight.
//   Reset (rst_n low, synchronous): table emptied, tracked id set to 0,
//   no result pending; ready for a transaction on the next cycle.
// ----------------------------------------------------------------------------
module contact_refcount_table #(
  parameter int CONTACT_SLOTS = crt_pkg::DEF_CONTACT_SLOTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_command,
  input  wire logic [crt_pkg::BODY_W-1:0]   in_body_a,
  input  wire logic [crt_pkg::BODY_W-1:0]   in_body_b,
  output logic                              out_valid,
  output logic [crt_pkg::EV_W-1:0]          out_event_res,
  output logic [crt_pkg::BODY_W-1:0]        out_peer_body,
  output logic [crt_pkg::COUNT_W-1:0]       out_pair_count,
  input  wire logic                         cfg_we,
  input  wire logic [crt_pkg::BODY_W-1:0]   cfg_wdata
);

  crt_pkg::ctl_t ctl;

  crt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  crt_datapath #(
    .CONTACT_SLOTS (CONTACT_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_peer_body  (out_peer_body),
    .out_pair_count (out_pair_count)
  );

endmodule
`default_nettype wire

@@ tb/sv/crt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_checker
// Watches the transaction, result and register ports of the contact table,
// keeps its own copy of the contact table, predicts the result of every
// accepted transaction and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module crt_checker #(
  parameter int SLOTS = crt_pkg::DEF_CONTACT_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic                       in_command,
  input  wire logic [crt_pkg::BODY_W-1:0] in_body_a,
  input  wire logic [crt_pkg::BODY_W-1:0] in_body_b,
  input  wire logic                       out_valid,
  input  wire logic [crt_pkg::EV_W-1:0]   out_event_res,
  input  wire logic [crt_pkg::BODY_W-1:0] out_peer_body,
  input  wire logic [crt_pkg::COUNT_W-1:0] out_pair_count,
  input  wire logic                       cfg_we,
  input  wire logic [crt_pkg::BODY_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              outstanding
);

  typedef struct packed {
    logic [crt_pkg::EV_W-1:0]    ev;
    logic [crt_pkg::BODY_W-1:0]  other;
    logic [crt_pkg::COUNT_W-1:0] pairs;
  } contact_result_t;

  logic [crt_pkg::BODY_W-1:0]  tracked_body;
  logic                        ent_live  [SLOTS];
  logic [crt_pkg::BODY_W-1:0]  ent_body  [SLOTS];
  logic [crt_pkg::COUNT_W-1:0] ent_pairs [SLOTS];

  contact_result_t pending_events[$];
  int              fail_cnt = 0;

  assign errors = fail_cnt;

  function automatic contact_result_t predict_contact(
    input logic                       cmd,
    input logic [crt_pkg::BODY_W-1:0] a,
    input logic [crt_pkg::BODY_W-1:0] b
  );
    contact_result_t            r;
    logic [crt_pkg::BODY_W-1:0] other;
    int                         hit;
    int                         vac;
    r.ev    = crt_pkg::EV_NONE;
    r.other = '0;
    r.pairs = '0;
    hit     = -1;
    vac     = -1;
    if (a == tracked_body) begin
      other = b;
    end else if (b == tracked_body) begin
      other = a;
    end else begin
      return r;
    end
    r.other = other;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && ent_live[i] && ent_body[i] == other) hit = i;
      if (vac < 0 && !ent_live[i]) vac = i;
    end
    if (cmd == crt_pkg::CMD_BEGIN) begin
      if (hit >= 0) begin
        if (ent_pairs[hit] != crt_pkg::COUNT_MAX) ent_pairs[hit] = ent_pairs[hit] + 1'b1;
        r.pairs = ent_pairs[hit];
      end else if (vac >= 0) begin
        ent_live[vac]  = 1'b1;
        ent_body[vac]  = other;
        ent_pairs[vac] = crt_pkg::COUNT_W'(1);
        r.ev           = crt_pkg::EV_BEGAN;
        r.pairs        = crt_pkg::COUNT_W'(1);
      end else begin
        r.ev = crt_pkg::EV_FULL;
      end
    end else if (hit >= 0) begin
      if (ent_pairs[hit] > crt_pkg::COUNT_W'(1)) begin
        ent_pairs[hit] = ent_pairs[hit] - 1'b1;
        r.pairs        = ent_pairs[hit];
      end else begin
        ent_live[hit] = 1'b0;
        r.ev          = crt_pkg::EV_ENDED;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    contact_result_t exp_r;
    if (!rst_n) begin
      tracked_body = '0;
      for (int i = 0; i < SLOTS; i++) begin
        ent_live[i]  = 1'b0;
        ent_body[i]  = '0;
        ent_pairs[i] = '0;
      end
      pending_events.delete();
    end else begin
      if (out_valid) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result ev %h peer %h count %h", $time,
                   out_event_res, out_peer_body, out_pair_count);
          fail_cnt++;
        end else begin
          exp_r = pending_events.pop_front();
          if (out_event_res !== exp_r.ev) begin
            $display("%0t: event_res expected %h actual %h", $time, exp_r.ev,
                     out_event_res);
            fail_cnt++;
          end
          if (out_peer_body !== exp_r.other) begin
            $display("%0t: peer_body expected %h actual %h", $time, exp_r.other,
                     out_peer_body);
            fail_cnt++;
          end
          if (out_pair_count !== exp_r.pairs) begin
            $display("%0t: pair_count expected %h actual %h", $time, exp_r.pairs,
                     out_pair_count);
            fail_cnt++;
          end
        end
      end
      if (start && !busy)
        pending_events.push_back(predict_contact(in_command, in_body_a, in_body_b));
      if (cfg_we) tracked_body = cfg_wdata;
    end
    outstanding = pending_events.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the contact reference count table: directed
// contact events covering every outcome, a table fill with one dropped
// contact, then random begin/end traffic on a shared body pool under several
// tracked body ids, sent in bursts with random gaps except in one phase.
// Checking is done by crt_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS       = crt_pkg::DEF_CONTACT_SLOTS;
  localparam int POOL_N      = 24;
  localparam int PHASE_ITEMS = 290;
  localparam int LIMIT       = 60000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        in_command = crt_pkg::CMD_BEGIN;
  logic [crt_pkg::BODY_W-1:0]  in_body_a = '0;
  logic [crt_pkg::BODY_W-1:0]  in_body_b = '0;
  logic                        out_valid;
  logic [crt_pkg::EV_W-1:0]    out_event_res;
  logic [crt_pkg::BODY_W-1:0]  out_peer_body;
  logic [crt_pkg::COUNT_W-1:0] out_pair_count;
  logic                        cfg_we = 1'b0;
  logic [crt_pkg::BODY_W-1:0]  cfg_wdata = '0;

  int errors;
  int outstanding;
  int cycle_cnt = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  logic [crt_pkg::BODY_W-1:0] own_id;
  logic [crt_pkg::BODY_W-1:0] body_pool [POOL_N];

  always #4 clk = ~clk;

  contact_refcount_table #(.CONTACT_SLOTS(SLOTS)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_peer_body  (out_peer_body),
    .out_pair_count (out_pair_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  crt_checker #(.SLOTS(SLOTS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_peer_body  (out_peer_body),
    .out_pair_count (out_pair_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_event(input logic cmd, input logic [crt_pkg::BODY_W-1:0] a,
                            input logic [crt_pkg::BODY_W-1:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 7);
      burst_left = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    start      <= 1'b1;
    in_command <= cmd;
    in_body_a  <= a;
    in_body_b  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_own(input logic [crt_pkg::BODY_W-1:0] v);
    own_id = v;
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // own id on a random side of the pair
  task automatic send_pair(input logic cmd, input logic [crt_pkg::BODY_W-1:0] other);
    if ($urandom_range(0, 1))
      send_event(cmd, own_id, other);
    else
      send_event(cmd, other, own_id);
  endtask

  task automatic random_phase(input int n_items);
    int                         done;
    int                         r;
    logic                       cmd;
    logic [crt_pkg::BODY_W-1:0] x;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        cmd = ($urandom_range(0, 99) < 55) ? crt_pkg::CMD_BEGIN : crt_pkg::CMD_END;
        send_pair(cmd, body_pool[$urandom_range(0, POOL_N - 1)]);
        done++;
      end else if (r < 88) begin
        cmd = 1'($urandom_range(0, 1));
        send_event(cmd, $urandom, $urandom);
      end else if (r < 93) begin
        cmd = 1'($urandom_range(0, 1));
        send_event(cmd, own_id, own_id);
        done++;
      end else begin
        x = $urandom;
        send_pair(crt_pkg::CMD_END, x);
        done++;
      end
    end
  endtask

  initial begin
    logic [crt_pkg::BODY_W-1:0] dir_own;
    logic [crt_pkg::BODY_W-1:0] phase_own [4];
    dir_own = 32'hA5C3_0F96;
    for (int i = 0; i < POOL_N; i++) body_pool[i] = $urandom;
    phase_own[0] = '0;
    phase_own[1] = '1;
    phase_own[2] = $urandom;
    phase_own[3] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed outcomes
    set_own(dir_own);
    send_event(crt_pkg::CMD_BEGIN, '0, '1);
    send_event(crt_pkg::CMD_END, '1, '0);
    send_event(crt_pkg::CMD_BEGIN, dir_own, '0);
    send_event(crt_pkg::CMD_BEGIN, '1, dir_own);
    send_event(crt_pkg::CMD_BEGIN, dir_own, '0);
    send_event(crt_pkg::CMD_END, '0, dir_own);
    send_event(crt_pkg::CMD_END, dir_own, '0);
    send_event(crt_pkg::CMD_END, dir_own, '0);
    send_event(crt_pkg::CMD_BEGIN, dir_own, dir_own);
    send_event(crt_pkg::CMD_END, dir_own, dir_own);
    send_event(crt_pkg::CMD_END, dir_own, '1);

    // fill the table, then one more begin is dropped
    for (int i = 0; i < SLOTS; i++) send_pair(crt_pkg::CMD_BEGIN, body_pool[i]);
    send_pair(crt_pkg::CMD_BEGIN, body_pool[SLOTS]);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_own(phase_own[p]);
      gaps_on = (p != 1);
      random_phase(PHASE_ITEMS);
      drain();
    end
    gaps_on = 1'b1;
    set_own(dir_own);
    random_phase(PHASE_ITEMS);
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/crt_pkg.sv
rtl/crt_ctrl.sv
rtl/crt_datapath.sv
rtl/contact_refcount_table.sv
tb/sv/crt_checker.sv
tb/sv/tb.sv
